>>> rtl/hevc_rtp_fragment_packetizer_defines.svh
// Assertion macros for the checker file of the packetizer.
`ifndef HEVC_RTP_FRAGMENT_PACKETIZER_DEFINES_SVH
`define HEVC_RTP_FRAGMENT_PACKETIZER_DEFINES_SVH

// Check on every clock edge, switched off while reset is asserted.
`define HRFP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define HRFP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/hrfp_pkg.sv
`timescale 1ns / 1ps

package hrfp_pkg;

    // Payload header of a fragmentation unit: type 49 shifted into place, layer 0, TID 1.
    localparam logic [7:0]  FU_PAYLOAD_HDR0 = 8'(49 << 1);
    localparam logic [7:0]  FU_PAYLOAD_HDR1 = 8'h01;
    localparam logic [5:0]  TYPE_MASK       = 6'h3F;
    localparam logic [7:0]  FU_S_BIT        = 8'(1 << 7);
    localparam logic [7:0]  FU_E_BIT        = 8'(1 << 6);

    // Payload limit register.
    localparam int          PAYLOAD_BITS    = 12;
    localparam logic [11:0] MIN_PAYLOAD     = 12'd16;
    localparam logic [11:0] RESET_PAYLOAD   = 12'd1400;

    // Defaults for the top level parameters.
    localparam int          DEFAULT_LENGTH_BITS = 24;
    localparam int          DEFAULT_QUEUE_DEPTH = 4;

    // One input beat.
    typedef struct packed {
        logic [7:0]  nal_byte;
        logic        nal_start;
        logic [23:0] nal_length;
    } hrfp_in_t;

    // One output beat.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        packet_first;
        logic        packet_last;
        logic [15:0] seq_number;
        logic        run_last;
    } hrfp_out_t;

    // Work handed from the front to the back: one data byte, optionally
    // preceded by the three fragment header bytes.
    typedef struct packed {
        logic [7:0]  data;
        logic        pkt_first;
        logic        pkt_last;
        logic        frag_start;
        logic [7:0]  fu_byte;
        logic [15:0] seq;
    } hrfp_cmd_t;

    // Position of the back end within one command.
    typedef enum logic [1:0] {
        BEAT_PH0,
        BEAT_PH1,
        BEAT_FUH,
        BEAT_DATA
    } hrfp_beat_t;

endpackage

>>> rtl/hrfp_front.sv
`timescale 1ns / 1ps

module hrfp_front
    import hrfp_pkg::*;
#(
    parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  hrfp_in_t                in_item,
    input  logic                    queue_full,
    input  logic                    cfg_valid,
    input  logic [PAYLOAD_BITS-1:0] cfg_data,
    output logic                    wr_en,
    output hrfp_cmd_t               wr_cmd
);

    logic [PAYLOAD_BITS-1:0] max_payload_reg;
    logic [LENGTH_BITS-1:0]  bytes_left_reg, bytes_left_next;
    logic                    frag_mode_reg, frag_mode_next;
    logic [1:0]              hdr_index_reg, hdr_index_next;
    logic [5:0]              unit_type_reg, unit_type_next;
    logic [PAYLOAD_BITS-1:0] chunk_fill_reg, chunk_fill_next;
    logic                    first_frag_reg, first_frag_next;
    logic [15:0]             pkt_count_reg, pkt_count_next;

    logic                    accept;
    logic                    start;
    logic [31:0]             len_wide;
    logic [LENGTH_BITS-1:0]  len;
    logic [PAYLOAD_BITS-1:0] limit;
    logic                    open_pkt;
    logic [LENGTH_BITS-1:0]  bl;
    logic                    fm;
    logic [1:0]              hi;
    logic [PAYLOAD_BITS-1:0] cf;
    logic [PAYLOAD_BITS-1:0] cf_inc;
    logic [LENGTH_BITS-1:0]  bl_dec;
    logic                    ff;
    logic [15:0]             pc;
    logic                    last;

    assign accept   = push && !queue_full;
    assign start    = in_item.nal_start;
    assign len_wide = 32'(in_item.nal_length);
    assign len      = len_wide[LENGTH_BITS-1:0];
    assign limit    = (max_payload_reg < MIN_PAYLOAD) ? MIN_PAYLOAD : max_payload_reg;
    assign open_pkt = frag_mode_reg ? (chunk_fill_reg != '0) : (bytes_left_reg != '0);

    // State as seen after a unit start has been applied.
    assign bl     = start ? len : bytes_left_reg;
    assign fm     = start ? (32'(len) > 32'(limit)) : frag_mode_reg;
    assign hi     = start ? 2'd0 : hdr_index_reg;
    assign cf     = start ? '0 : chunk_fill_reg;
    assign ff     = start ? 1'b1 : first_frag_reg;
    assign pc     = (start && open_pkt) ? pkt_count_reg + 16'd1 : pkt_count_reg;
    assign cf_inc = cf + PAYLOAD_BITS'(1);
    assign bl_dec = bl - LENGTH_BITS'(1);

    // Classify the byte and work out the state it leaves behind.
    always_comb
    begin
        bytes_left_next = bl;
        frag_mode_next  = fm;
        hdr_index_next  = hi;
        unit_type_next  = start ? (in_item.nal_byte[6:1] & TYPE_MASK) : unit_type_reg;
        chunk_fill_next = cf;
        first_frag_next = ff;
        pkt_count_next  = pc;
        last            = 1'b0;
        wr_en           = 1'b0;

        wr_cmd.data       = in_item.nal_byte;
        wr_cmd.pkt_first  = 1'b0;
        wr_cmd.pkt_last   = 1'b0;
        wr_cmd.frag_start = 1'b0;
        wr_cmd.fu_byte    = {2'b00, unit_type_next};
        wr_cmd.seq        = pc;

        if (bl != '0)
        begin
            if (!fm)
            begin
                // Single NAL unit packet: the byte passes through.
                last             = (bl == LENGTH_BITS'(1));
                wr_en            = accept;
                wr_cmd.pkt_first = start;
                wr_cmd.pkt_last  = last;
                bytes_left_next  = bl_dec;
                if (last)
                begin
                    pkt_count_next = pc + 16'd1;
                end
            end
            else if (hi < 2'd2)
            begin
                // NAL header bytes of a fragmented unit are swallowed.
                hdr_index_next  = hi + 2'd1;
                bytes_left_next = bl_dec;
            end
            else
            begin
                // Fragment body; a new fragment opens with its header bytes.
                wr_en             = accept;
                wr_cmd.frag_start = (cf == '0);
                wr_cmd.fu_byte    = {2'b00, unit_type_reg}
                                  | (ff ? FU_S_BIT : 8'h00)
                                  | ((32'(bl) <= 32'(limit)) ? FU_E_BIT : 8'h00);
                if (cf == '0)
                begin
                    first_frag_next = 1'b0;
                end
                bytes_left_next = bl_dec;
                last            = (cf_inc >= limit) || (bl_dec == '0);
                wr_cmd.pkt_last = last;
                if (last)
                begin
                    chunk_fill_next = '0;
                    pkt_count_next  = pc + 16'd1;
                end
                else
                begin
                    chunk_fill_next = cf_inc;
                end
                if (bl_dec == '0)
                begin
                    frag_mode_next = 1'b0;
                end
            end
        end
    end

    // Unit state, updated once per accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= '0;
            frag_mode_reg  <= 1'b0;
            hdr_index_reg  <= 2'd0;
            unit_type_reg  <= 6'd0;
            chunk_fill_reg <= '0;
            first_frag_reg <= 1'b0;
            pkt_count_reg  <= 16'd0;
        end
        else if (accept)
        begin
            bytes_left_reg <= bytes_left_next;
            frag_mode_reg  <= frag_mode_next;
            hdr_index_reg  <= hdr_index_next;
            unit_type_reg  <= unit_type_next;
            chunk_fill_reg <= chunk_fill_next;
            first_frag_reg <= first_frag_next;
            pkt_count_reg  <= pkt_count_next;
        end
    end

    // Payload limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= RESET_PAYLOAD;
        end
        else if (cfg_valid)
        begin
            max_payload_reg <= cfg_data;
        end
    end

endmodule

>>> rtl/hrfp_queue.sv
`timescale 1ns / 1ps

module hrfp_queue
    import hrfp_pkg::*;
#(
    parameter int DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  hrfp_cmd_t wr_cmd,
    input  logic      rd_en,
    output hrfp_cmd_t rd_cmd,
    output logic      q_full,
    output logic      q_empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    hrfp_cmd_t             slot_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  do_wr;
    logic                  do_rd;

    assign q_full  = (count_reg == CNT_BITS'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_cmd  = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_BITS'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_BITS'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots carry payload only.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

>>> rtl/hrfp_back.sv
`timescale 1ns / 1ps

module hrfp_back
    import hrfp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  hrfp_cmd_t rd_cmd,
    input  logic      q_empty,
    output logic      rd_en,
    input  logic      pop,
    output logic      empty,
    output hrfp_out_t out_item
);

    hrfp_cmd_t  cur_reg;
    logic       cur_valid_reg, cur_valid_next;
    hrfp_beat_t beat_reg, beat_next;
    logic       final_beat;
    logic       take;

    assign empty      = !cur_valid_reg;
    assign final_beat = (beat_reg == BEAT_DATA);
    assign take       = pop && cur_valid_reg;
    assign rd_en      = !q_empty && (!cur_valid_reg || (take && final_beat));

    // Step through the beats of the current command, then load the next one.
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        beat_next      = beat_reg;
        if (rd_en)
        begin
            cur_valid_next = 1'b1;
            beat_next      = rd_cmd.frag_start ? BEAT_PH0 : BEAT_DATA;
        end
        else if (take)
        begin
            case (beat_reg)
                BEAT_PH0:  beat_next = BEAT_PH1;
                BEAT_PH1:  beat_next = BEAT_FUH;
                BEAT_FUH:  beat_next = BEAT_DATA;
                default:   cur_valid_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            beat_reg      <= BEAT_DATA;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            beat_reg      <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            cur_reg <= rd_cmd;
        end
    end

    // Result beat for the current position.
    always_comb
    begin
        out_item.seq_number   = cur_reg.seq;
        out_item.run_last     = final_beat;
        out_item.packet_first = 1'b0;
        out_item.packet_last  = 1'b0;
        case (beat_reg)
            BEAT_PH0:
            begin
                out_item.out_byte     = FU_PAYLOAD_HDR0;
                out_item.packet_first = 1'b1;
            end
            BEAT_PH1:
            begin
                out_item.out_byte = FU_PAYLOAD_HDR1;
            end
            BEAT_FUH:
            begin
                out_item.out_byte = cur_reg.fu_byte;
            end
            default:
            begin
                out_item.out_byte     = cur_reg.data;
                out_item.packet_first = cur_reg.pkt_first;
                out_item.packet_last  = cur_reg.pkt_last;
            end
        endcase
    end

endmodule

>>> rtl/hevc_rtp_fragment_packetizer.sv
`timescale 1ns / 1ps

// H.265 RTP packetizer: turns a NAL unit byte stream into single-unit packets
// or fragmentation units with their payload and FU headers.
// Input channel: push/full with one NAL byte per beat; the beat that carries
// nal_start also carries the unit length. Output channel: empty/pop, one
// payload byte per beat with packet boundary flags and the sequence number.
// Configuration: cfg_valid/cfg_ready/cfg_data writes the payload limit; it is
// always ready and should only be written while the block is idle.
// Each command is written into the queue, then loaded into the output register
// before its beats show. Throughput: one input byte per cycle while full is low.
// The first data byte of each fragment expands to four output beats, which the
// output side drains at one beat per cycle while pop is high; the command queue
// (QUEUE_DEPTH entries) absorbs that burst, and full rises once the queue fills.
// When the receiver stalls, the current beat holds and the queue fills; full
// then holds off the sender without losing data.
// Reset clears the unit state, the sequence number and the queue, and sets the
// payload limit to 1400 bytes.
module hevc_rtp_fragment_packetizer
    import hrfp_pkg::*;
#(
    parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS,
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  hrfp_in_t                in_item,
    output logic                    empty,
    input  logic                    pop,
    output hrfp_out_t               out_item,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [PAYLOAD_BITS-1:0] cfg_data
);

    logic      wr_en;
    hrfp_cmd_t wr_cmd;
    logic      rd_en;
    hrfp_cmd_t rd_cmd;
    logic      q_empty;

    assign cfg_ready = 1'b1;

    // Front: unit state and classification of each byte.
    hrfp_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .in_item    (in_item),
        .queue_full (full),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .wr_en      (wr_en),
        .wr_cmd     (wr_cmd)
    );

    // Command queue between the two sides.
    hrfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_cmd  (wr_cmd),
        .rd_en   (rd_en),
        .rd_cmd  (rd_cmd),
        .q_full  (full),
        .q_empty (q_empty)
    );

    // Back: expands each command into output beats.
    hrfp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_cmd   (rd_cmd),
        .q_empty  (q_empty),
        .rd_en    (rd_en),
        .pop      (pop),
        .empty    (empty),
        .out_item (out_item)
    );

endmodule

>>> rtl/hrfp_checker.sv
`timescale 1ns / 1ps

`include "hevc_rtp_fragment_packetizer_defines.svh"

module hrfp_checker
    import hrfp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input hrfp_out_t out_item
);

    // The queue and the output register come out of reset with nothing held.
    `HRFP_ASSERT_ALWAYS(a_reset_clear, $rose(rst_n) |-> (empty && !full), "not clear after reset")

    // The last byte of a packet always ends the run of its input byte.
    `HRFP_ASSERT(a_last_ends_run, (!empty && out_item.packet_last) |-> out_item.run_last, "packet_last without run_last")

    // Header beats are followed at once by the rest of the run, same packet.
    `HRFP_ASSERT(a_run_continues, (pop && !empty && !out_item.run_last) |=> (!empty && $stable(out_item.seq_number)), "run broken")

    // A waiting beat holds while it is not taken.
    `HRFP_ASSERT(a_stall_holds, (!empty && !pop) |=> (!empty && $stable(out_item)), "stalled beat changed")

endmodule

bind hevc_rtp_fragment_packetizer hrfp_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
);

>>> test/hevc_rtp_fragment_packetizer_tb.sv
`timescale 1ns / 1ps

module hevc_rtp_fragment_packetizer_tb;
    import hrfp_pkg::*;

    // Predicts the payload beats of the packetizer and checks them in order.
    class payload_scoreboard;
        logic [11:0] limit;
        logic [23:0] bytes_left;
        bit          frag_mode;
        logic [1:0]  hdr_count;
        logic [5:0]  unit_type;
        logic [11:0] chunk_fill;
        bit          first_frag;
        logic [15:0] seq;
        hrfp_out_t   expected_q[$];
        int          errors;
        int          nal_beats;
        int          payload_beats;
        int          packets;
        int          fragments;

        function new();
            limit      = RESET_PAYLOAD;
            bytes_left = '0;
            frag_mode  = 1'b0;
            hdr_count  = '0;
            unit_type  = '0;
            chunk_fill = '0;
            first_frag = 1'b0;
            seq        = '0;
            errors     = 0;
        endfunction

        function void set_limit(input logic [11:0] value);
            limit = value;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        // Queue one payload beat stamped with the current sequence number.
        function void add_beat(input logic [7:0] b, input bit first, input bit last);
            hrfp_out_t r;
            r.out_byte     = b;
            r.packet_first = first;
            r.packet_last  = last;
            r.seq_number   = seq;
            r.run_last     = 1'b0;
            expected_q.push_back(r);
            if (last)
                packets++;
        endfunction

        // Work out the payload beats caused by one accepted NAL byte.
        function void absorb_nal_byte(input hrfp_in_t beat);
            logic [11:0] eff;
            logic [7:0]  fu;
            bit          open_pkt;
            bit          last;
            int          base;

            eff  = (limit < MIN_PAYLOAD) ? MIN_PAYLOAD : limit;
            base = expected_q.size();
            nal_beats++;

            // A new unit abandons any unfinished one; an open packet uses up its number.
            if (beat.nal_start)
            begin
                open_pkt = frag_mode ? (chunk_fill != 0) : (bytes_left != 0);
                if (open_pkt)
                    seq++;
                bytes_left = beat.nal_length;
                hdr_count  = '0;
                chunk_fill = '0;
                first_frag = 1'b1;
                frag_mode  = (beat.nal_length > eff);
                unit_type  = beat.nal_byte[6:1] & TYPE_MASK;
            end

            // Stray bytes and zero length units produce nothing.
            if (bytes_left == 0)
                return;

            if (!frag_mode)
            begin
                last = (bytes_left == 1);
                add_beat(beat.nal_byte, beat.nal_start, last);
                bytes_left--;
                if (last)
                    seq++;
            end
            else if (hdr_count < 2)
            begin
                // The two NAL header bytes are replaced by the fragment headers.
                hdr_count++;
                bytes_left--;
                return;
            end
            else
            begin
                if (chunk_fill == 0)
                begin
                    fu = {2'b00, unit_type};
                    if (first_frag)
                        fu = fu | FU_S_BIT;
                    if (bytes_left <= eff)
                        fu = fu | FU_E_BIT;
                    first_frag = 1'b0;
                    fragments++;
                    add_beat(FU_PAYLOAD_HDR0, 1'b1, 1'b0);
                    add_beat(FU_PAYLOAD_HDR1, 1'b0, 1'b0);
                    add_beat(fu, 1'b0, 1'b0);
                end
                chunk_fill++;
                bytes_left--;
                last = (chunk_fill >= eff) || (bytes_left == 0);
                add_beat(beat.nal_byte, 1'b0, last);
                if (last)
                begin
                    chunk_fill = '0;
                    seq++;
                end
                if (bytes_left == 0)
                    frag_mode = 1'b0;
            end

            if (expected_q.size() > base)
                expected_q[expected_q.size() - 1].run_last = 1'b1;
        endfunction

        // Compare one popped beat with the oldest expectation.
        function void match_payload_beat(input hrfp_out_t got);
            hrfp_out_t want;

            payload_beats++;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat: expected none, got byte %h first %b last %b seq %0d run_last %b",
                         $time, got.out_byte, got.packet_first, got.packet_last,
                         got.seq_number, got.run_last);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
            begin
                errors++;
                $display("%0t: beat %0d: expected byte %h first %b last %b seq %0d run_last %b, got byte %h first %b last %b seq %0d run_last %b",
                         $time, payload_beats, want.out_byte, want.packet_first,
                         want.packet_last, want.seq_number, want.run_last,
                         got.out_byte, got.packet_first, got.packet_last,
                         got.seq_number, got.run_last);
            end
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    push = 1'b0;
    logic                    full;
    hrfp_in_t                in_item = '0;
    logic                    empty;
    logic                    pop = 1'b0;
    hrfp_out_t               out_item;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [PAYLOAD_BITS-1:0] cfg_data = '0;

    payload_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int limit_settings = 0;

    hevc_rtp_fragment_packetizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Result side: check each popped beat, then decide whether to pop next cycle.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.match_payload_beat(out_item);
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #5_000_000;
        $display("[hevc_rtp_fragment_packetizer] ERROR");
        $finish;
    end

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                send_idle_pct = 33;
                recv_idle_pct = 85;
            end
            1:
            begin
                send_idle_pct = 85;
                recv_idle_pct = 33;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // Offer one NAL byte, with random idle cycles first, and wait until it is taken.
    task automatic send_beat(input hrfp_in_t beat);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        in_item <= beat;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.absorb_nal_byte(beat);
    endtask

    // Send the first nbytes of a unit declared as len bytes long.
    task automatic send_unit(input int unsigned len, input int unsigned nbytes);
        hrfp_in_t beat;
        for (int unsigned i = 0; i < nbytes; i++)
        begin
            beat.nal_byte   = 8'($urandom);
            beat.nal_start  = (i == 0);
            beat.nal_length = (i == 0) ? 24'(len) : 24'($urandom);
            send_beat(beat);
        end
    endtask

    task automatic send_strays(input int unsigned count);
        hrfp_in_t beat;
        for (int unsigned i = 0; i < count; i++)
        begin
            beat.nal_byte   = 8'($urandom);
            beat.nal_start  = 1'b0;
            beat.nal_length = 24'($urandom);
            send_beat(beat);
        end
    endtask

    // Stop sending until every expected beat has come, then let the pipeline settle.
    task automatic drain_payload;
        int waited;
        waited = 0;
        push <= 1'b0;
        while (sb.outstanding() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_payload_limit(input logic [11:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_limit(value);
        limit_settings++;
    endtask

    // Stimulus and end of run.
    initial
    begin
        logic [11:0] phase_limit [6];
        int unsigned eff;
        int unsigned max_len;
        int unsigned len;
        int budget;
        int unsigned pick;
        int left;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        set_idling(0);

        // Directed part at the reset limit.
        send_beat('{nal_byte: 8'hFF, nal_start: 1'b0, nal_length: 24'hFFFFFF});
        send_beat('{nal_byte: 8'h00, nal_start: 1'b1, nal_length: 24'h000000});
        send_beat('{nal_byte: 8'hFF, nal_start: 1'b1, nal_length: 24'h000001});
        send_unit(5, 5);
        send_unit(24'hFFFFFF, 3);
        send_unit(4, 4);
        drain_payload();

        // Directed part at the smallest limit, written below the floor.
        write_payload_limit(12'd0);
        send_unit(16, 16);
        send_unit(17, 17);
        send_unit(34, 34);
        send_unit(40, 1);
        send_unit(40, 18);
        send_unit(40, 10);
        send_unit(20, 25);
        send_beat('{nal_byte: 8'h00, nal_start: 1'b1, nal_length: 24'h000000});
        drain_payload();

        phase_limit[0] = 12'd15;
        phase_limit[1] = 12'd4095;
        phase_limit[2] = 12'($urandom_range(16, 64));
        phase_limit[3] = 12'd0;
        phase_limit[4] = 12'($urandom_range(17, 40));
        phase_limit[5] = 12'd16;

        // Random phases, one limit each, idling pattern changing every two phases.
        for (int p = 0; p < 6; p++)
        begin
            drain_payload();
            write_payload_limit(phase_limit[p]);
            set_idling(p / 2);
            eff     = (phase_limit[p] < MIN_PAYLOAD) ? MIN_PAYLOAD : phase_limit[p];
            max_len = (eff <= 64) ? 2 * eff + 3 : 40;

            budget = sb.nal_beats + 12;
            while (sb.nal_beats < budget)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    len = $urandom_range(1, max_len);
                    send_unit(len, len);
                end
                else if (pick < 80)
                begin
                    // Unit cut short by the next start.
                    len = ($urandom_range(1) == 1) ? ($urandom & 32'hFFFFFF)
                                                   : $urandom_range(eff + 1, eff + max_len);
                    if (len == 0)
                        len = 1;
                    left = $urandom_range(1, (len < max_len) ? len : max_len);
                    send_unit(len, left);
                end
                else if (pick < 88)
                begin
                    len = $urandom_range(1, max_len);
                    send_unit(len, len + $urandom_range(1, 3));
                end
                else if (pick < 94)
                    send_strays($urandom_range(1, 3));
                else
                    send_unit(0, 1);

                if ($urandom_range(49) == 0)
                    drain_payload();
            end
        end

        drain_payload();
        repeat (20) @(posedge clk);
        if (sb.outstanding() != 0)
        begin
            $display("%0t: %0d expected beats never arrived", $time, sb.outstanding());
            sb.errors += sb.outstanding();
        end

        $display("Sent %0d NAL bytes under %0d payload limit settings; checked %0d beats",
                 sb.nal_beats, limit_settings, sb.payload_beats);
        $display("covering %0d packets and %0d fragments, with restarts, strays and zero lengths",
                 sb.packets, sb.fragments);
        if (sb.errors == 0)
            $display("[hevc_rtp_fragment_packetizer] OK");
        else
            $display("[hevc_rtp_fragment_packetizer] ERROR");
        $finish;
    end

endmodule
